/* src/lslc_pkg.sv */
// Package: operation codes, pixel type and blend helper for the strip compositor.
`timescale 1ns / 1ps
package lslc_pkg;
	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_SOLID  = 3'd1,
		OP_PIXEL  = 3'd2,
		OP_MAX    = 3'd3,
		OP_GRAD   = 3'd4,
		OP_ROTATE = 3'd5,
		OP_READ   = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	// new = (c*a >> 8) + (old*(256-a) >> 8), truncated to 8 bits
	function automatic logic [7:0] mix_chan(input logic [7:0] c, input logic [7:0] a,
			input logic [7:0] old);
		logic [15:0] p1;
		logic [16:0] p2;
		logic [8:0]  inv;
		logic [8:0]  s;
		inv = 9'd256 - {1'b0, a};
		p1 = c * a;
		p2 = old * inv;
		s = {1'b0, p1[15:8]} + {1'b0, p2[15:8]};
		return s[7:0];
	endfunction
endpackage

/* src/led_strip_layer_compositor_core.sv */
// Top level: strip memory, sweep sequencer and read-out for the compositor.
// Operation: clear, blend and max sweep the W pixels (reads, write-back, then idle);
// one-pixel blend touches one pixel; gradient first runs four slope divisions unless its ends clamp equal;
// rotate first reduces the offset, then copies the strip into the shadow before the sweep.
// Throughput: one request at a time; read-out issues no new pixel while one is still in flight.
// Reset: a clearing pass zeroes the memory; no request is taken.
`timescale 1ns / 1ps
module led_strip_layer_compositor_core #(
	parameter int MAX_PIXELS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	input  logic [7:0]  red_b,
	input  logic [7:0]  green_b,
	input  logic [7:0]  blue_b,
	input  logic [7:0]  alpha_b,
	input  logic signed [15:0] position_a,
	input  logic signed [15:0] position_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  pixel_number,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        last
);
	import lslc_pkg::*;

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam logic [6:0] MAXW = 7'(MAX_PIXELS);

	typedef enum logic [7:0] {
		S_INIT  = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_DIV   = 8'b0000_0100,
		S_COPY  = 8'b0000_1000,
		S_SWEEP = 8'b0001_0000,
		S_READ  = 8'b0010_0000,
		S_DRAIN = 8'b0100_0000,
		S_ODRN  = 8'b1000_0000
	} state_t;

	state_t state_q;
	pixel_t mem [MAX_PIXELS];
	pixel_t shadow [MAX_PIXELS];
	pixel_t rd_s1;
	pixel_t srd_s1;

	logic [6:0] active_q;
	logic [6:0] w_q;
	op_t        op_q;
	logic [7:0] r_q, g_q, b_q, a_q;
	logic signed [9:0] c1_q [4];
	logic signed [9:0] c2_q [4];
	logic signed [9:0] slope_q [4];
	logic signed [8:0] p1_q, p2_q;
	logic [6:0] idx_q;
	logic [6:0] off_q;
	logic [1:0] dch_q;

	// stage 1 of sweep: address in flight
	logic        v_s1;
	logic [AW-1:0] a_s1;
	logic        grad_in_s1;
	logic [7:0]  t_s1 [4];
	logic        last_s1;
	logic        copy_s1;

	// clamp and effective width
	function automatic logic [6:0] cfg_eff(input logic [6:0] v);
		if (v == 7'd0) return 7'd1;
		if (v > MAXW) return MAXW;
		return v;
	endfunction
	logic [6:0] w_eff;
	assign w_eff = (cfg_eff(active_q));

	function automatic logic signed [8:0] clampp(input logic signed [15:0] p,
			input logic [6:0] w);
		logic signed [15:0] hi;
		hi = 16'(w) + 16'sd20;
		if (p > hi) return hi[8:0];
		if (p < -16'sd20) return -9'sd20;
		return p[8:0];
	endfunction

	logic signed [8:0] cp1, cp2;
	assign cp1 = clampp(position_a, w_eff);
	assign cp2 = clampp(position_b, w_eff);

	// rotate offset, reduced into 0..w-1 in S_DIV by coarse 64*w steps, then w steps
	logic signed [16:0] rot_q;

	// divider
	logic div_start, div_done;
	logic signed [9:0] div_q;
	logic signed [9:0] div_num;
	logic [6:0] div_den;
	assign div_num = c2_q[dch_q] - c1_q[dch_q];
	assign div_den = 7'(p2_q - p1_q);
	lslc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quotient(div_q)
	);
	logic div_busy_q;

	assign in_stall = (state_q != S_IDLE);

	// output register
	logic ov_q;
	assign out_valid = ov_q;
	logic out_free;
	assign out_free = !ov_q || !out_stall;

	// pixel position for the sweep, relative to p1 for gradient
	logic [AW-1:0] addr;
	assign addr = idx_q[AW-1:0];
	logic signed [9:0] gi;
	assign gi = $signed({3'b0, idx_q}) - 10'(p1_q);

	// read-out issues only when the output register is sure to be free on arrival
	logic issue;
	always_comb begin
		issue = 1'b0;
		case (state_q)
			S_SWEEP: issue = 1'b1;
			S_READ:  issue = out_free && !v_s1;
			default: issue = 1'b0;
		endcase
	end

	logic in_span;
	assign in_span = ($signed({3'b0, idx_q}) >= 10'(p1_q))
		&& ($signed({3'b0, idx_q}) <= 10'(p2_q));

	// source index for rotate
	logic [7:0] src_sum;
	logic [6:0] src;
	assign src_sum = {1'b0, idx_q} + {1'b0, off_q};
	assign src = (src_sum >= {1'b0, w_q}) ? 7'(src_sum - {1'b0, w_q}) : src_sum[6:0];

	logic accept;
	assign accept = in_valid && !in_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			active_q <= 7'd64;
			idx_q <= '0;
			v_s1 <= 1'b0;
			ov_q <= 1'b0;
			dch_q <= '0;
			div_busy_q <= 1'b0;
			op_q <= OP_NONE;
		end else begin
			if (cfg_we) active_q <= cfg_wdata;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			v_s1 <= 1'b0;
			case (state_q)
				S_INIT: begin
					idx_q <= idx_q + 7'd1;
					if (idx_q == MAXW - 7'd1) begin
						state_q <= S_IDLE;
						idx_q <= '0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q <= op_t'(operation);
						idx_q <= '0;
						dch_q <= '0;
						case (op_t'(operation))
							OP_CLEAR, OP_SOLID, OP_MAX: state_q <= S_SWEEP;
							OP_PIXEL: begin
								if (position_a >= 0 && position_a < $signed({9'b0, w_eff})) begin
									idx_q <= position_a[6:0];
									state_q <= S_SWEEP;
								end
							end
							OP_GRAD, OP_ROTATE: state_q <= S_DIV;
							OP_READ: state_q <= S_READ;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DIV: begin
					if (op_q == OP_ROTATE) begin
						// bring offset into 0..w-1 by coarse 64*w steps, then w steps
						if (rot_q < 0) begin
							;
						end else if (rot_q < $signed({10'b0, w_q})) begin
							state_q <= S_COPY;
						end
					end else if (p2_q == p1_q) begin
						idx_q <= (p1_q < 0) ? 7'd0 : 7'(p1_q);
						state_q <= S_SWEEP;
					end else if (!div_busy_q) begin
						div_busy_q <= 1'b1;
					end else if (div_done) begin
						div_busy_q <= 1'b0;
						dch_q <= dch_q + 2'd1;
						if (dch_q == 2'd3) begin
							idx_q <= (p1_q < 0) ? 7'd0 : 7'(p1_q);
							state_q <= S_SWEEP;
						end
					end
				end
				// the copy runs one index past the last pixel so the last copied pixel lands before the sweep reads
				S_COPY: begin
					idx_q <= idx_q + 7'd1;
					if (idx_q == w_q) begin
						idx_q <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					v_s1 <= 1'b1;
					idx_q <= idx_q + 7'd1;
					if (op_q == OP_PIXEL || idx_q == w_q - 7'd1
							|| (op_q == OP_GRAD && $signed({3'b0, idx_q}) >= 10'(p2_q)))
						state_q <= S_DRAIN;
				end
				S_READ: begin
					if (issue) begin
						v_s1 <= 1'b1;
						idx_q <= idx_q + 7'd1;
						if (idx_q == w_q - 7'd1) state_q <= S_ODRN;
					end
					if (v_s1) ov_q <= 1'b1;
				end
				S_ODRN: begin
					if (v_s1) ov_q <= 1'b1;
					if (!v_s1) state_q <= S_IDLE;
				end
				S_DRAIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign div_start = (state_q == S_DIV) && (op_q == OP_GRAD) && !div_busy_q
		&& (p2_q != p1_q);

	// operand registers
	always_ff @(posedge clk) begin
		if (accept) begin
			w_q <= w_eff;
			r_q <= red; g_q <= green; b_q <= blue; a_q <= alpha;
			rot_q <= 17'(position_a);
			if (cp1 > cp2) begin
				p1_q <= cp2; p2_q <= cp1;
				c1_q[0] <= 10'(red_b); c1_q[1] <= 10'(green_b);
				c1_q[2] <= 10'(blue_b); c1_q[3] <= 10'(alpha_b);
				c2_q[0] <= 10'(red); c2_q[1] <= 10'(green);
				c2_q[2] <= 10'(blue); c2_q[3] <= 10'(alpha);
			end else begin
				p1_q <= cp1; p2_q <= cp2;
				c1_q[0] <= 10'(red); c1_q[1] <= 10'(green);
				c1_q[2] <= 10'(blue); c1_q[3] <= 10'(alpha);
				c2_q[0] <= 10'(red_b); c2_q[1] <= 10'(green_b);
				c2_q[2] <= 10'(blue_b); c2_q[3] <= 10'(alpha_b);
			end
			for (int k = 0; k < 4; k++) slope_q[k] <= '0;
		end else if (state_q == S_DIV && op_q == OP_ROTATE) begin
			// step offset toward 0..w-1, one w per cycle once it is within 64*w,
			// via coarse steps of 64*w first
			if (rot_q < 0) begin
				if (rot_q < -$signed(17'({w_q, 6'b0}))) rot_q <= rot_q + 17'({w_q, 6'b0});
				else rot_q <= rot_q + 17'(w_q);
			end else if (rot_q >= $signed({10'b0, w_q})) begin
				if (rot_q >= $signed(17'({w_q, 6'b0}))) rot_q <= rot_q - 17'({w_q, 6'b0});
				else rot_q <= rot_q - 17'(w_q);
			end
			off_q <= rot_q[6:0];
		end else if (div_done) begin
			slope_q[dch_q] <= div_q;
		end
	end

	// gradient channel values: c1 + (i-p1)*s, one narrow multiply per channel
	logic signed [19:0] gprod [4];
	always_comb begin
		for (int k = 0; k < 4; k++) gprod[k] = 20'(c1_q[k]) + 20'(gi) * 20'(slope_q[k]);
	end

	// stage 1 register: read memory, capture sweep context
	always_ff @(posedge clk) begin
		rd_s1 <= mem[addr];
		srd_s1 <= shadow[src[AW-1:0]];
		a_s1 <= addr;
		last_s1 <= (idx_q == w_q - 7'd1);
		grad_in_s1 <= in_span && (idx_q < w_q);
		copy_s1 <= (state_q == S_COPY) && (idx_q < w_q);
		for (int k = 0; k < 4; k++) t_s1[k] <= gprod[k][7:0];
	end

	// shadow copy for rotate, from the registered memory read
	always_ff @(posedge clk) begin
		if (copy_s1) shadow[a_s1] <= rd_s1;
	end

	// write-back stage
	pixel_t nv;
	logic   wr;
	always_comb begin
		nv = rd_s1;
		wr = v_s1;
		case (op_q)
			OP_CLEAR: nv = '0;
			OP_SOLID, OP_PIXEL: begin
				nv.r = mix_chan(r_q, a_q, rd_s1.r);
				nv.g = mix_chan(g_q, a_q, rd_s1.g);
				nv.b = mix_chan(b_q, a_q, rd_s1.b);
			end
			OP_MAX: begin
				nv.r = (r_q > rd_s1.r) ? r_q : rd_s1.r;
				nv.g = (g_q > rd_s1.g) ? g_q : rd_s1.g;
				nv.b = (b_q > rd_s1.b) ? b_q : rd_s1.b;
			end
			OP_GRAD: begin
				wr = v_s1 && grad_in_s1;
				nv.r = mix_chan(t_s1[0], t_s1[3], rd_s1.r);
				nv.g = mix_chan(t_s1[1], t_s1[3], rd_s1.g);
				nv.b = mix_chan(t_s1[2], t_s1[3], rd_s1.b);
			end
			OP_ROTATE: begin
				nv.r = mix_chan(srd_s1.r, 8'd255, rd_s1.r);
				nv.g = mix_chan(srd_s1.g, 8'd255, rd_s1.g);
				nv.b = mix_chan(srd_s1.b, 8'd255, rd_s1.b);
			end
			default: wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_INIT) mem[addr] <= '0;
		else if (wr && state_q != S_READ && state_q != S_ODRN) mem[a_s1] <= nv;
	end

	// output register
	always_ff @(posedge clk) begin
		if (v_s1 && (state_q == S_READ || state_q == S_ODRN)) begin
			pixel_number <= 6'(a_s1);
			out_red <= rd_s1.r;
			out_green <= rd_s1.g;
			out_blue <= rd_s1.b;
			last <= last_s1;
		end
	end

	// no new request while a sweep is running
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> in_stall)
		else $error("request taken during sweep");
	a_noovr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside gradient setup");
endmodule

/* src/lslc_divider.sv */
// Module: signed restoring divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps
module lslc_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [9:0]  dividend,
	input  logic [6:0]         divisor,
	output logic               done,
	output logic signed [9:0]  quotient
);
	logic [8:0] rem_q;
	logic [8:0] mag_q;
	logic [8:0] quo_q;
	logic [6:0] den_q;
	logic       neg_q;
	logic [3:0] cnt_q;
	logic       busy_q;
	logic [9:0] trial;
	logic [8:0] shifted;

	assign shifted = {rem_q[7:0], mag_q[8]};
	assign trial = {1'b0, shifted} - {3'b0, den_q};

	// step one bit per cycle while busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 4'd9;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			mag_q <= dividend[9] ? 9'(-dividend) : dividend[8:0];
			neg_q <= dividend[9];
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[7:0], 1'b0};
			if (!trial[9]) begin
				rem_q <= trial[8:0];
				quo_q <= {quo_q[7:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[7:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the LED strip layer compositor core.
`timescale 1ns / 1ps
module tb_top;
	import lslc_pkg::*;

	localparam int NPIX = 64;
	localparam int LIMIT_NS = 200_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] operation = '0;
	logic [7:0] red = '0, green = '0, blue = '0, alpha = '0;
	logic [7:0] red_b = '0, green_b = '0, blue_b = '0, alpha_b = '0;
	logic signed [15:0] position_a = '0, position_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] pixel_number;
	logic [7:0] out_red, out_green, out_blue;
	logic last;

	typedef struct packed {
		logic [5:0] idx;
		pixel_t     px;
		logic       last;
	} readout_t;

	typedef struct {
		op_t op;
		logic [7:0] c1 [4];
		logic [7:0] c2 [4];
		int pa;
		int pb;
	} request_t;

	pixel_t   strip [NPIX];
	int       width_reg;
	readout_t readout_q [$];
	int       errors;
	int       send_idle_pct;
	int       recv_stall_pct;

	led_strip_layer_compositor_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.red(red), .green(green), .blue(blue), .alpha(alpha),
		.red_b(red_b), .green_b(green_b), .blue_b(blue_b), .alpha_b(alpha_b),
		.position_a(position_a), .position_b(position_b),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_number(pixel_number),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue), .last(last)
	);

	always #6 clk = ~clk;

	function automatic int eff_width();
		if (width_reg < 1) return 1;
		if (width_reg > NPIX) return NPIX;
		return width_reg;
	endfunction

	function automatic logic [7:0] blend8(int c, int a, int old);
		int s;
		s = ((c * a) >> 8) + ((old * (256 - a)) >> 8);
		return s[7:0];
	endfunction

	function automatic pixel_t blend_px(pixel_t o, int r, int g, int b, int a);
		pixel_t n;
		n.r = blend8(r, a, o.r);
		n.g = blend8(g, a, o.g);
		n.b = blend8(b, a, o.b);
		return n;
	endfunction

	// Apply one request to the shadow strip and queue any read-out pixels
	task automatic predict_strip(request_t q);
		int w, p1, p2, d, off, src, i, k;
		int s1 [4];
		int s2 [4];
		int sl [4];
		int t [4];
		pixel_t snap [NPIX];
		readout_t ro;
		w = eff_width();
		case (q.op)
			OP_CLEAR: for (i = 0; i < w; i++) strip[i] = '0;
			OP_SOLID: for (i = 0; i < w; i++)
				strip[i] = blend_px(strip[i], q.c1[0], q.c1[1], q.c1[2], q.c1[3]);
			OP_PIXEL: if (q.pa >= 0 && q.pa < w)
				strip[q.pa] = blend_px(strip[q.pa], q.c1[0], q.c1[1], q.c1[2], q.c1[3]);
			OP_MAX: for (i = 0; i < w; i++) begin
				if (q.c1[0] > strip[i].r) strip[i].r = q.c1[0];
				if (q.c1[1] > strip[i].g) strip[i].g = q.c1[1];
				if (q.c1[2] > strip[i].b) strip[i].b = q.c1[2];
			end
			OP_GRAD: begin
				p1 = q.pa; p2 = q.pb;
				for (k = 0; k < 4; k++) begin
					s1[k] = q.c1[k]; s2[k] = q.c2[k];
				end
				if (p1 > w + 20) p1 = w + 20;
				if (p1 < -20) p1 = -20;
				if (p2 > w + 20) p2 = w + 20;
				if (p2 < -20) p2 = -20;
				// swap so the span runs upward
				if (p1 > p2) begin
					d = p1; p1 = p2; p2 = d;
					for (k = 0; k < 4; k++) begin
						d = s1[k]; s1[k] = s2[k]; s2[k] = d;
					end
				end
				d = p2 - p1;
				for (k = 0; k < 4; k++) sl[k] = (d <= 0) ? 0 : (s2[k] - s1[k]) / d;
				for (i = p1; i <= p2; i++) if (i >= 0 && i < w) begin
					for (k = 0; k < 4; k++) t[k] = (s1[k] + (i - p1) * sl[k]) & 255;
					strip[i] = blend_px(strip[i], t[0], t[1], t[2], t[3]);
				end
			end
			OP_ROTATE: begin
				off = q.pa % w;
				if (off < 0) off += w;
				for (i = 0; i < w; i++) snap[i] = strip[i];
				for (i = 0; i < w; i++) begin
					src = i + off;
					if (src >= w) src -= w;
					strip[i] = blend_px(snap[i], snap[src].r, snap[src].g, snap[src].b, 255);
				end
			end
			OP_READ: for (i = 0; i < w; i++) begin
				ro.idx = i[5:0];
				ro.px = strip[i];
				ro.last = (i == w - 1);
				readout_q.push_back(ro);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Drive one request and hold it until accepted
	task automatic send_request(request_t q);
		@(posedge clk);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		operation <= q.op;
		red <= q.c1[0]; green <= q.c1[1]; blue <= q.c1[2]; alpha <= q.c1[3];
		red_b <= q.c2[0]; green_b <= q.c2[1]; blue_b <= q.c2[2]; alpha_b <= q.c2[3];
		position_a <= q.pa[15:0];
		position_b <= q.pb[15:0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_strip(q);
		in_valid <= 1'b0;
	endtask

	function automatic request_t make_req(op_t op, int pa, int pb);
		request_t q;
		q.op = op;
		for (int k = 0; k < 4; k++) begin
			q.c1[k] = 8'($urandom);
			q.c2[k] = 8'($urandom);
		end
		q.pa = pa;
		q.pb = pb;
		return q;
	endfunction

	// Wait for all read-out pixels, then for the block to go idle
	task automatic wait_idle();
		@(posedge clk);
		while (readout_q.size() != 0 || in_stall || out_valid) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_width(int w);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= w[6:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = w;
	endtask

	// Drive the output stall
	always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Check each read-out pixel against the oldest expectation
	always @(posedge clk) begin
		readout_t exp_ro;
		if (arst_n && out_valid && !out_stall) begin
			if (readout_q.size() == 0) begin
				report_mismatch("unexpected read-out pixel");
			end else begin
				exp_ro = readout_q.pop_front();
				if (pixel_number !== exp_ro.idx)
					report_mismatch($sformatf("pixel_number %0d exp %0d", pixel_number, exp_ro.idx));
				if (out_red !== exp_ro.px.r)
					report_mismatch($sformatf("red px %0d: %h exp %h", exp_ro.idx, out_red, exp_ro.px.r));
				if (out_green !== exp_ro.px.g)
					report_mismatch($sformatf("green px %0d: %h exp %h", exp_ro.idx, out_green,
						exp_ro.px.g));
				if (out_blue !== exp_ro.px.b)
					report_mismatch($sformatf("blue px %0d: %h exp %h", exp_ro.idx, out_blue,
						exp_ro.px.b));
				if (last !== exp_ro.last)
					report_mismatch($sformatf("last px %0d: %b exp %b", exp_ro.idx, last, exp_ro.last));
			end
		end
	end

	task automatic test_directed();
		request_t q;
		send_request(make_req(OP_READ, 0, 0));
		q = make_req(OP_SOLID, 0, 0);
		q.c1 = '{8'hff, 8'h00, 8'h80, 8'hff};
		send_request(q);
		q = make_req(OP_SOLID, 0, 0);
		q.c1[3] = 8'h00;
		send_request(q);
		send_request(make_req(OP_PIXEL, 0, 0));
		send_request(make_req(OP_PIXEL, 63, 0));
		send_request(make_req(OP_PIXEL, -1, 0));
		send_request(make_req(OP_PIXEL, 64, 0));
		send_request(make_req(OP_MAX, 0, 0));
		send_request(make_req(OP_READ, 0, 0));
		send_request(make_req(OP_GRAD, 5, 40));
		send_request(make_req(OP_GRAD, 50, 3));
		send_request(make_req(OP_GRAD, 17, 17));
		send_request(make_req(OP_GRAD, -32768, 32767));
		send_request(make_req(OP_GRAD, 32767, -32768));
		send_request(make_req(OP_READ, 0, 0));
		send_request(make_req(OP_ROTATE, 3, 0));
		send_request(make_req(OP_ROTATE, -5, 0));
		send_request(make_req(OP_ROTATE, -32768, 0));
		send_request(make_req(OP_NONE, 0, 0));
		send_request(make_req(OP_READ, 0, 0));
		send_request(make_req(OP_CLEAR, 0, 0));
		send_request(make_req(OP_READ, 0, 0));
	endtask

	function automatic int rand_pos(int w);
		case ($urandom_range(3))
			0: return $signed(16'($urandom));
			1: return $urandom_range(w + 30) - 25;
			default: return $urandom_range(w - 1);
		endcase
	endfunction

	task automatic test_random(int n);
		request_t q;
		int w;
		for (int j = 0; j < n; j++) begin
			w = eff_width();
			q = make_req(op_t'($urandom_range(7)), rand_pos(w), rand_pos(w));
			if ($urandom_range(9) == 0) q.c1[3] = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
			if ($urandom_range(4) == 0) q.op = OP_READ;
			send_request(q);
		end
		send_request(make_req(OP_READ, 0, 0));
	endtask

	task automatic test_widths();
		int widths [6] = '{1, 0, 127, 2, 37, 64};
		foreach (widths[m]) begin
			write_width(widths[m]);
			test_random(10);
		end
	endtask

	task automatic test_idling();
		int send_pct [4] = '{0, 82, 0, 31};
		int recv_pct [4] = '{0, 0, 82, 31};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			write_width(($urandom_range(1) != 0) ? 64 : $urandom_range(1, 64));
			test_random(15);
		end
	endtask

	initial begin
		errors = 0;
		width_reg = 64;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (strip[i]) strip[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 31;
		recv_stall_pct = 31;
		test_widths();
		test_idling();
		wait_idle();
		if (errors == 0 && readout_q.size() == 0) begin
			$display("[led_strip_layer_compositor_core] OK");
		end else begin
			$display("[led_strip_layer_compositor_core] ERROR");
		end
		$finish;
	end

	initial begin
		#LIMIT_NS;
		$display("[led_strip_layer_compositor_core] ERROR");
		$finish;
	end
endmodule
